[rtl/tsvf_pkg.sv]
// Package for the state variable filter: widths, register indexes, reset values,
// sequencer and multiplier types, and the saturation helpers.
// Depends on nothing; every other file in rtl uses it.
package tsvf_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int STATE_W  = 32;
  localparam int DIGIT_W  = 8;
  localparam int DIGITS   = COEF_W / DIGIT_W;
  localparam int CNT_W    = $clog2(DIGITS);
  // Rounded product of a state-width signal and a coefficient, shifted by 24.
  localparam int PROD_W   = STATE_W + DIGIT_W + 1;
  // Wide enough for a difference of two products and a state.
  localparam int SUM_W    = PROD_W + 2;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_GAIN    = 2'd0;
  localparam cfg_index_t REG_DAMPING = 2'd1;
  localparam cfg_index_t REG_NORM    = 2'd2;

  localparam logic [COEF_W-1:0] GAIN_RESET    = 32'd1677722;
  localparam logic [COEF_W-1:0] DAMPING_RESET = 32'd23726566;
  localparam logic [COEF_W-1:0] NORM_RESET    = 32'd8388608;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GO,
    ST_WAIT,
    ST_FIN
  } seq_state_t;

  // The five products of one update, in the order they are formed.
  typedef enum logic [2:0] {
    MUL_SG,
    MUL_SR,
    MUL_VH,
    MUL_HG,
    MUL_BG
  } mul_step_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Clamp to the signed 32-bit range.
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v[SUM_W-1:STATE_W-1] == '0 || v[SUM_W-1:STATE_W-1] == '1) begin
      r = v[STATE_W-1:0];
    end else begin
      r = v[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp to the signed 24-bit output range.
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[STATE_W-1:SAMPLE_W-1] == '0 || v[STATE_W-1:SAMPLE_W-1] == '1) begin
      r = v[SAMPLE_W-1:0];
    end else begin
      r = v[STATE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/tsvf_sample_if.sv]
// Valid/ready channel that carries one input audio sample per request.
// Depends on tsvf_pkg for the sample width.
interface tsvf_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tsvf_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

[rtl/tsvf_result_if.sv]
// Valid/ready channel that carries the lowpass and highpass outputs of one update.
// Depends on tsvf_pkg for the sample width.
interface tsvf_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tsvf_pkg::SAMPLE_W-1:0] lowpass_out;
  logic signed [tsvf_pkg::SAMPLE_W-1:0] highpass_out;

  modport source (output valid, output lowpass_out, output highpass_out, input ready);
  modport sink (input valid, input lowpass_out, input highpass_out, output ready);
endinterface

[rtl/tsvf_dmul.sv]
// Digit-serial multiplier: signed 32-bit signal times unsigned Q8.24 coefficient,
// one 8-bit coefficient digit per cycle, result rounded half up and shifted by 24.
// Depends on tsvf_pkg.
module tsvf_dmul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [tsvf_pkg::STATE_W-1:0] a,
  input  logic        [tsvf_pkg::COEF_W-1:0]  c,
  output tsvf_pkg::mul_stat_t                  stat,
  output logic signed [tsvf_pkg::PROD_W-1:0]  p
);
  import tsvf_pkg::*;

  localparam int ACC_W = STATE_W + 1;
  localparam int LO_W  = 2 * DIGIT_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIGITS - 1);

  logic signed [STATE_W-1:0] a_reg;
  logic        [COEF_W-1:0]  c_sh;
  logic signed [ACC_W-1:0]   acc;
  logic        [LO_W-1:0]    lo;
  logic        [CNT_W-1:0]   cnt;
  logic                      busy;
  logic                      fin;
  logic                      done;

  logic signed [PROD_W-1:0]  part;
  logic signed [PROD_W-1:0]  sum;

  // One partial product per cycle; the low digit drops into lo, the rest shifts down.
  assign part = a_reg * $signed({1'b0, c_sh[DIGIT_W-1:0]});
  assign sum  = PROD_W'(acc) + part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      c_sh  <= c;
      acc   <= '0;
    end else if (busy) begin
      acc  <= sum[PROD_W-1:DIGIT_W];
      lo   <= {sum[DIGIT_W-1:0], lo[LO_W-1:DIGIT_W]};
      c_sh <= c_sh >> DIGIT_W;
    end
    // Bit 23 of the full product decides the half-up rounding.
    if (fin) begin
      p <= $signed({acc, lo[LO_W-1:DIGIT_W]}) + $signed({{(PROD_W-1){1'b0}}, lo[DIGIT_W-1]});
    end
  end

  assign stat.busy = busy | fin;
  assign stat.done = done;

endmodule

[rtl/tpt_state_variable_filter.sv]
// Top level of the trapezoidal state variable filter: sequencer, coefficient
// registers and integrator states. Depends on tsvf_pkg, tsvf_sample_if,
// tsvf_result_if and tsvf_dmul.
//
// Usage:
//   Each request on the samples channel carries one signed 24-bit audio sample.
//   The block runs one update of the two-integrator structure and posts one
//   request on the results channel with the lowpass and highpass outputs.
//   The three coefficients (unsigned Q8.24) are written through the plain write
//   port: cfg_wr_en high at a rising edge writes cfg_data into the register
//   named by cfg_index; unknown indexes are ignored. Write only while idle.
// Sequencing:
//   The five products of an update go one after another through a single
//   digit-serial multiplier that handles eight coefficient bits per cycle;
//   each product is issued, computed and rounded before the next starts. The
//   block accepts a new sample only once the previous update has ended and
//   the sequencer is back in its idle state.
// Reset and stalls:
//   Reset clears both integrators, loads the default coefficients and empties
//   the output register. A finished result waits in the output register; the
//   next sample is accepted and processed meanwhile, and only its final write
//   waits until the receiver has taken the previous result.
module tpt_state_variable_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  tsvf_pkg::cfg_index_t                cfg_index,
  input  logic        [tsvf_pkg::COEF_W-1:0] cfg_data,
  tsvf_sample_if.sink                         samples,
  tsvf_result_if.source                       results
);
  import tsvf_pkg::*;

  // Coefficient registers.
  logic [COEF_W-1:0] gain;
  logic [COEF_W-1:0] damping;
  logic [COEF_W-1:0] norm;

  // Sequencer.
  seq_state_t state;
  seq_state_t state_next;
  mul_step_t  step;
  mul_step_t  step_next;

  // Integrators and intermediate signals of the update.
  logic signed [STATE_W-1:0]  s1;
  logic signed [STATE_W-1:0]  s2;
  logic signed [STATE_W:0]    diff;
  logic signed [PROD_W:0]     acc;
  logic signed [STATE_W-1:0]  v;
  logic signed [STATE_W-1:0]  hp;
  logic signed [STATE_W-1:0]  bp;
  logic signed [STATE_W-1:0]  lp;
  logic signed [PROD_W-1:0]   tg;

  // Output register.
  logic                       res_valid;
  logic signed [SAMPLE_W-1:0] lp_out;
  logic signed [SAMPLE_W-1:0] hp_out;

  // Multiplier connection.
  logic                       mul_start;
  logic signed [STATE_W-1:0]  mul_a;
  logic        [COEF_W-1:0]   mul_c;
  mul_stat_t                  mul_stat;
  logic signed [PROD_W-1:0]   mul_p;

  logic item_take;
  logic mul_fin;
  logic out_free;

  assign item_take = samples.valid && samples.ready;
  assign mul_fin   = (state == ST_WAIT) && mul_stat.done;
  assign out_free  = !res_valid || results.ready;

  tsvf_dmul u_dmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .c     (mul_c),
    .stat  (mul_stat),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain    <= GAIN_RESET;
      damping <= DAMPING_RESET;
      norm    <= NORM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN:    gain    <= cfg_data;
        REG_DAMPING: damping <= cfg_data;
        REG_NORM:    norm    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= MUL_SG;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    mul_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = ST_GO;
          step_next  = MUL_SG;
        end
      end
      ST_GO: begin
        mul_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_stat.done) begin
          state_next = ST_GO;
          unique case (step)
            MUL_SG: step_next = MUL_SR;
            MUL_SR: step_next = MUL_VH;
            MUL_VH: step_next = MUL_HG;
            MUL_HG: step_next = MUL_BG;
            MUL_BG: state_next = ST_FIN;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Operands of each product: s1*g, s1*r, v*h, hp*g, bp*g.
  always_comb begin
    unique case (step)
      MUL_SG: begin
        mul_a = s1;
        mul_c = gain;
      end
      MUL_SR: begin
        mul_a = s1;
        mul_c = damping;
      end
      MUL_VH: begin
        mul_a = v;
        mul_c = norm;
      end
      MUL_HG: begin
        mul_a = hp;
        mul_c = gain;
      end
      default: begin
        mul_a = bp;
        mul_c = gain;
      end
    endcase
  end

  // The integrators are filter state and are cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      // The first integrator is final once hp*g and bp are known; the last
      // product does not read it.
      if (state == ST_GO && step == MUL_BG) begin
        s1 <= sat32(SUM_W'(tg) + SUM_W'(bp));
      end
      if (state == ST_FIN && out_free) begin
        s2 <= sat32(SUM_W'(tg) + SUM_W'(lp));
      end
    end
  end

  // Intermediate signals of the update; each is written once per item, except tg (hp*g, then bp*g).
  always_ff @(posedge clk) begin
    if (item_take) begin
      diff <= (STATE_W+1)'(samples.sample_in) - (STATE_W+1)'(s2);
    end
    if (mul_fin) begin
      unique case (step)
        MUL_SG: acc <= (PROD_W+1)'(diff) - (PROD_W+1)'(mul_p);
        MUL_SR: v   <= sat32(SUM_W'(acc) - SUM_W'(mul_p));
        MUL_VH: hp  <= sat32(SUM_W'(mul_p));
        MUL_HG: begin
          tg <= mul_p;
          bp <= sat32(SUM_W'(mul_p) + SUM_W'(s1));
        end
        default: begin
          tg <= mul_p;
          lp <= sat32(SUM_W'(mul_p) + SUM_W'(s2));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      lp_out <= sat24(lp);
      hp_out <= sat24(hp);
    end
  end

  assign samples.ready        = (state == ST_IDLE);
  assign results.valid        = res_valid;
  assign results.lowpass_out  = lp_out;
  assign results.highpass_out = hp_out;

  // The multiplier is only started when it has nothing in flight.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // A finished product is only ever reported while the sequencer waits for it.
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> state == ST_WAIT)
    else $error("product finished outside the wait state");

  // An accepted sample always begins with the first product.
  a_take_start: assert property (@(posedge clk) disable iff (rst)
    item_take |=> (state == ST_GO && step == MUL_SG))
    else $error("accepted sample did not start the update");

  // A result is only posted from the final state of an update.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == ST_FIN)
    else $error("result posted outside the final state");

endmodule

[test/tb_tpt_state_variable_filter.sv]
// Self-checking testbench for the trapezoidal state variable filter.
// Depends on tsvf_pkg, tsvf_sample_if, tsvf_result_if and the filter RTL.
// Results are checked against a predictor of the fixed-point filter update.
module tb_tpt_state_variable_filter;
  import tsvf_pkg::*;

  // Index 3 is not decoded by the block, so a write to it must change nothing.
  localparam cfg_index_t REG_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam longint STATE_MAX = 64'sd2147483647;
  localparam longint STATE_MIN = -64'sd2147483648;

  // Once the last result is taken the block has no update left in flight, so
  // the settle periods below only guard against anything it might still emit.
  localparam int DRAIN_SETTLE   = 4;
  localparam int END_SETTLE     = 48;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Kinds of coefficient setting that the random phases go through.
  typedef enum int {
    SET_DEFAULT,
    SET_STABLE,
    SET_ZERO,
    SET_FULL,
    SET_RANDOM,
    SET_MIXED
  } coef_set_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] lowpass;
    logic signed [SAMPLE_W-1:0] highpass;
  } filter_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  cfg_index_t             cfg_index;
  logic [COEF_W-1:0]      cfg_data;

  tsvf_sample_if sample_ch ();
  tsvf_result_if result_ch ();

  tpt_state_variable_filter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  // Predictor copy of the coefficient registers and the two integrators.
  logic [COEF_W-1:0]         gain_q;
  logic [COEF_W-1:0]         damping_q;
  logic [COEF_W-1:0]         norm_q;
  logic signed [STATE_W-1:0] band_integ;
  logic signed [STATE_W-1:0] low_integ;

  filter_result_t expected_outputs[$];

  int  error_count     = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  settings_used   = 0;
  // When set, the matching side runs without idle cycles for a whole phase.
  bit  feed_steady     = 1'b0;
  bit  drain_steady    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded Q8.24 product: (a * c + 2^23) >> 24 with floor. The signal is
  // within the 32-bit range and the coefficient is unsigned 32-bit, so the
  // product always fits in 64 bits.
  function automatic longint coef_mult(input longint a, input logic [COEF_W-1:0] c);
    longint c_wide;
    longint prod;
    c_wide = longint'(c);
    prod = a * c_wide;
    return (prod + 64'sd8388608) >>> 24;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp24(input longint v);
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // One update of the two-integrator structure. Every intermediate signal but
  // the products hg and bg, and both integrators, saturate at 32 bits; the outputs saturate at 24.
  task automatic predict_update(input logic signed [SAMPLE_W-1:0] x);
    longint s1, s2, v, hp, hg, bp, bg, lp;
    filter_result_t res;
    s1 = longint'(band_integ);
    s2 = longint'(low_integ);
    v  = clamp32(longint'(x) - coef_mult(s1, gain_q) - coef_mult(s1, damping_q) - s2);
    hp = clamp32(coef_mult(v, norm_q));
    hg = coef_mult(hp, gain_q);
    bp = clamp32(hg + s1);
    band_integ = STATE_W'(clamp32(hg + bp));
    bg = coef_mult(bp, gain_q);
    lp = clamp32(bg + s2);
    low_integ = STATE_W'(clamp32(bg + lp));
    res.lowpass  = clamp24(lp);
    res.highpass = clamp24(hp);
    expected_outputs.push_back(res);
  endtask

  // Sends one sample request. The sender idles a random number of cycles
  // first unless the phase asks for a steady stream. Must be called right
  // after a rising edge, which every task here returns on.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_in <= x;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    predict_update(x);
    samples_sent++;
  endtask

  // Stops sending and waits until every predicted result has been checked,
  // then lets the block settle so that it is idle.
  task automatic wait_for_drain();
    sample_ch.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Writes all three coefficients on consecutive edges, optionally followed
  // by a write to the undecoded index, then drops the write enable. Only
  // called while the block is idle.
  task automatic write_coefs(input logic [COEF_W-1:0] g, input logic [COEF_W-1:0] r,
                             input logic [COEF_W-1:0] h, input bit poke_unused);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_GAIN;
    cfg_data  <= g;
    @(posedge clk);
    gain_q    = g;
    cfg_index <= REG_DAMPING;
    cfg_data  <= r;
    @(posedge clk);
    damping_q = r;
    cfg_index <= REG_NORM;
    cfg_data  <= h;
    @(posedge clk);
    norm_q    = h;
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= $urandom;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [COEF_W-1:0] edge_or_random();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Picks a coefficient set of the given kind. Stable sets are derived from
  // a random cutoff gain and damping, with a matching normalizer.
  task automatic pick_coefs(input coef_set_t kind, output logic [COEF_W-1:0] g,
                            output logic [COEF_W-1:0] r, output logic [COEF_W-1:0] h);
    real gf, rf, hf;
    case (kind)
      SET_DEFAULT: begin
        g = GAIN_RESET;
        r = DAMPING_RESET;
        h = NORM_RESET;
      end
      SET_STABLE: begin
        gf = 0.005 + 1.5 * $urandom_range(0, 1000) / 1000.0;
        rf = 0.05 + 2.0 * $urandom_range(0, 1000) / 1000.0;
        hf = 1.0 / (1.0 + rf * gf + gf * gf);
        g  = $rtoi(gf * 16777216.0 + 0.5);
        r  = $rtoi(rf * 16777216.0 + 0.5);
        h  = $rtoi(hf * 16777216.0 + 0.5);
      end
      SET_ZERO: begin
        g = '0;
        r = '0;
        h = '0;
      end
      SET_FULL: begin
        g = '1;
        r = '1;
        h = '1;
      end
      SET_RANDOM: begin
        g = $urandom;
        r = $urandom;
        h = $urandom;
      end
      default: begin
        g = edge_or_random();
        r = edge_or_random();
        h = edge_or_random();
      end
    endcase
  endtask

  // Random samples lean on the range ends and on small values so that both
  // saturation and the fine rounding of the products get exercised.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Reset coefficients with zero states: silence, both range ends, the
  // smallest steps, sustained steps at either end and alternating bit
  // patterns.
  task automatic test_default_response();
    logic signed [SAMPLE_W-1:0] seq [14] = '{
      24'sh000000, SAMPLE_MAX, SAMPLE_MIN, 24'sh000001, -24'sh000001, 24'sh000000,
      SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
      24'sh555555, 24'shAAAAAA
    };
    foreach (seq[i]) send_sample(seq[i]);
    wait_for_drain();
  endtask

  // All-ones coefficients drive every intermediate into saturation; all-zero
  // coefficients make the filter pass nothing through. The undecoded index
  // is written along the way and must leave the coefficients alone.
  task automatic test_saturation_corners();
    write_coefs('1, '1, '1, 1'b1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'sh000000);
    wait_for_drain();
    write_coefs('0, '0, '0, 1'b1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'sh000001);
    wait_for_drain();
  endtask

  // Random phases, each with its own coefficient set and flow pattern. The
  // first six phases go through every kind of set once so the extremes are
  // always covered. Once per phase the sender stops mid-stream until every
  // outstanding result has come back.
  task automatic test_random_settings();
    logic [COEF_W-1:0] g, r, h;
    coef_set_t kind;
    int pause_at;
    for (int phase = 0; phase < PHASES; phase++) begin
      kind = (phase < 6) ? coef_set_t'(phase) : coef_set_t'($urandom_range(0, 5));
      pick_coefs(kind, g, r, h);
      write_coefs(g, r, h, 1'($urandom_range(0, 1)));
      feed_steady  = ($urandom_range(0, 3) == 0);
      drain_steady = ($urandom_range(0, 3) == 0);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) wait_for_drain();
        send_sample(pick_sample());
      end
      wait_for_drain();
    end
    feed_steady  = 1'b0;
    drain_steady = 1'b0;
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= REG_GAIN;
    cfg_data            <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.sample_in <= '0;
    gain_q     = GAIN_RESET;
    damping_q  = DAMPING_RESET;
    norm_q     = NORM_RESET;
    band_integ = '0;
    low_integ  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_response();
    test_saturation_corners();
    test_random_settings();

    // Everything has been sent; wait for the last results and then watch a
    // little longer for anything the block should not produce.
    wait_for_drain();
    repeat (END_SETTLE) @(posedge clk);

    $display("Covered %0d samples and %0d checked results over %0d coefficient settings,",
             samples_sent, results_checked, settings_used);
    $display("including all-zero, all-ones, random and stable filter settings.");
    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: stalls a random number of cycles before each result unless the
  // phase asks for steady draining, then compares the accepted result with
  // the oldest prediction.
  initial begin : result_checker
    filter_result_t want;
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = drain_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      results_checked++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: lowpass_out %0d, highpass_out %0d",
               result_ch.lowpass_out, result_ch.highpass_out);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (result_ch.lowpass_out !== want.lowpass) begin
          $error("lowpass_out mismatch: expected %0d, actual %0d",
                 want.lowpass, result_ch.lowpass_out);
          error_count++;
        end
        if (result_ch.highpass_out !== want.highpass) begin
          $error("highpass_out mismatch: expected %0d, actual %0d",
                 want.highpass, result_ch.highpass_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, expected_outputs.size());
    $display("tb: failure");
    $finish;
  end

endmodule

[tpt_state_variable_filter.f]
rtl/tsvf_pkg.sv
rtl/tsvf_sample_if.sv
rtl/tsvf_result_if.sv
rtl/tsvf_dmul.sv
rtl/tpt_state_variable_filter.sv
test/tb_tpt_state_variable_filter.sv
